/* hw/rtl/llhs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llhs_pkg: shared definitions for the least loaded host selector
// Field widths, register indexes and the record type passed between stages.
// ----------------------------------------------------------------------------
package llhs_pkg;

    localparam int MAX_HOSTS  = 64;
    localparam int CNT_W      = $clog2(MAX_HOSTS);

    localparam int USERS_W    = 16;
    localparam int SVC_W      = 8;
    localparam int LIMIT_W    = 12;
    localparam int ACC_W      = 16;
    localparam int CAP_W      = SVC_W + LIMIT_W;
    localparam int REST_W     = CAP_W + 2;
    localparam int POS_W      = 6;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_SOFT_LIMIT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HARD_LIMIT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ACCURACY   = 2'd2;

    // One host record after its capacity has been worked out.
    typedef struct packed {
        logic [USERS_W-1:0]       users;
        logic signed [REST_W-1:0] soft_rest;
        logic signed [REST_W-1:0] hard_rest;
        logic                     can_load;
        logic                     last;
    } t_rest_item;

endpackage

/* hw/rtl/least_loaded_host_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_loaded_host_select: picks the lightest host of a list
// Host records stream in one per beat; the last one is marked, and one
// result beat gives the chosen position and whether the pick can take load.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake             Payload
//  record    in   i_valid / o_ready     i_host_users .. i_last_host
//  result    out  o_valid / i_ready     o_chosen_position, o_chosen_can_load,
//                                       o_order_changed
//  config    in   i_cfg_we              i_cfg_addr, i_cfg_wdata
//
// One record is taken every cycle unless a last record waits on a stalled
// result; the last record of a selection is loaded into the input register,
// then the capacity register, and its result then into the result register.
// The rate is set by the pick compare and update in the selection stage,
// which closes on itself once per cycle.
// Reset clears the pipeline valids, the record counter, the pick and the
// configuration. A stalled result holds only records marked last; others
// keep flowing past it.
// ----------------------------------------------------------------------------
module least_loaded_host_select (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [llhs_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [llhs_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [llhs_pkg::USERS_W-1:0]     i_host_users,
    input  logic [llhs_pkg::SVC_W-1:0]       i_online_services,
    input  logic [llhs_pkg::USERS_W-1:0]     i_host_soft_cap,
    input  logic [llhs_pkg::USERS_W-1:0]     i_host_hard_cap,
    input  logic                             i_host_can_load,
    input  logic                             i_last_host,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [llhs_pkg::POS_W-1:0]       o_chosen_position,
    output logic                             o_chosen_can_load,
    output logic                             o_order_changed
);
    import llhs_pkg::*;

    logic [LIMIT_W-1:0] r_soft_limit;
    logic [LIMIT_W-1:0] r_hard_limit;
    logic [ACC_W-1:0]   r_accuracy;

    logic               w_item_valid;
    t_rest_item         w_item;
    logic               w_take;

    // Writes to an index beyond the register list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_soft_limit <= '0;
            r_hard_limit <= '0;
            r_accuracy   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SOFT_LIMIT: r_soft_limit <= i_cfg_wdata[LIMIT_W-1:0];
                REG_HARD_LIMIT: r_hard_limit <= i_cfg_wdata[LIMIT_W-1:0];
                REG_ACCURACY:   r_accuracy   <= i_cfg_wdata[ACC_W-1:0];
                default: ;
            endcase
        end
    end

    llhs_rest u_rest (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_soft_limit      (r_soft_limit),
        .i_hard_limit      (r_hard_limit),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_host_users      (i_host_users),
        .i_online_services (i_online_services),
        .i_host_soft_cap   (i_host_soft_cap),
        .i_host_hard_cap   (i_host_hard_cap),
        .i_host_can_load   (i_host_can_load),
        .i_last_host       (i_last_host),
        .o_item_valid      (w_item_valid),
        .o_item            (w_item),
        .i_take            (w_take)
    );

    llhs_pick u_pick (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accuracy        (r_accuracy),
        .i_item_valid      (w_item_valid),
        .i_item            (w_item),
        .o_take            (w_take),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_chosen_position (o_chosen_position),
        .o_chosen_can_load (o_chosen_can_load),
        .o_order_changed   (o_order_changed)
    );

endmodule

/* hw/rtl/llhs_rest.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llhs_rest: input register and capacity stage
// Registers each host record, forms soft and hard rest capacity and holds
// the result in a second register for the selection stage.
// ----------------------------------------------------------------------------
module llhs_rest (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [llhs_pkg::LIMIT_W-1:0]    i_soft_limit,
    input  logic [llhs_pkg::LIMIT_W-1:0]    i_hard_limit,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [llhs_pkg::USERS_W-1:0]    i_host_users,
    input  logic [llhs_pkg::SVC_W-1:0]      i_online_services,
    input  logic [llhs_pkg::USERS_W-1:0]    i_host_soft_cap,
    input  logic [llhs_pkg::USERS_W-1:0]    i_host_hard_cap,
    input  logic                            i_host_can_load,
    input  logic                            i_last_host,
    output logic                            o_item_valid,
    output llhs_pkg::t_rest_item            o_item,
    input  logic                            i_take
);
    import llhs_pkg::*;

    logic               r_in_valid;
    logic [USERS_W-1:0] r_users;
    logic [SVC_W-1:0]   r_svcs;
    logic [USERS_W-1:0] r_scap;
    logic [USERS_W-1:0] r_hcap;
    logic               r_can_load;
    logic               r_last;

    logic               r_item_valid;
    t_rest_item         r_item;
    t_rest_item         n_item;

    logic               w_s2_free;
    logic               w_s1_adv;
    logic               w_accept;

    logic [CAP_W-1:0]   w_soft_cap;
    logic [CAP_W-1:0]   w_hard_cap;

    assign w_s2_free = !r_item_valid || i_take;
    assign w_s1_adv  = r_in_valid && w_s2_free;
    assign o_ready   = !r_in_valid || w_s1_adv;
    assign w_accept  = i_valid && o_ready;

    // A nonzero host cap clips the cap from the role limit.
    always_comb begin
        w_soft_cap = CAP_W'(r_svcs * i_soft_limit);
        if (r_scap != '0 && w_soft_cap > CAP_W'(r_scap)) begin
            w_soft_cap = CAP_W'(r_scap);
        end
        w_hard_cap = CAP_W'(r_svcs * i_hard_limit);
        if (r_hcap != '0 && w_hard_cap > CAP_W'(r_hcap)) begin
            w_hard_cap = CAP_W'(r_hcap);
        end
    end

    always_comb begin
        n_item.users     = r_users;
        n_item.soft_rest = $signed({2'b00, w_soft_cap}) - $signed(REST_W'(r_users));
        n_item.hard_rest = $signed({2'b00, w_hard_cap}) - $signed(REST_W'(r_users));
        n_item.can_load  = r_can_load;
        n_item.last      = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_item_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_item_valid <= 1'b1;
            end else if (i_take) begin
                r_item_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_users    <= i_host_users;
            r_svcs     <= i_online_services;
            r_scap     <= i_host_soft_cap;
            r_hcap     <= i_host_hard_cap;
            r_can_load <= i_host_can_load;
            r_last     <= i_last_host;
        end
        if (w_s1_adv) begin
            r_item <= n_item;
        end
    end

    assign o_item_valid = r_item_valid;
    assign o_item       = r_item;

    // A record waiting for the selection stage must not change under it.
    a_item_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_item_valid && !i_take |=> r_item_valid && $stable(r_item))
        else $error("capacity stage record changed while held");

endmodule

/* hw/rtl/llhs_pick.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llhs_pick: selection stage and result register
// Compares each record with the running pick, updates the pick and issues
// the result beat on the last record of a selection.
// ----------------------------------------------------------------------------
module llhs_pick (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [llhs_pkg::ACC_W-1:0]      i_accuracy,
    input  logic                            i_item_valid,
    input  llhs_pkg::t_rest_item            i_item,
    output logic                            o_take,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [llhs_pkg::POS_W-1:0]      o_chosen_position,
    output logic                            o_chosen_can_load,
    output logic                            o_order_changed
);
    import llhs_pkg::*;

    logic [USERS_W-1:0]       r_pick_users;
    logic signed [REST_W-1:0] r_pick_soft;
    logic signed [REST_W-1:0] r_pick_hard;
    logic                     r_pick_can_load;
    logic [CNT_W-1:0]         r_pick_pos;
    logic                     r_pick_moved;
    logic [CNT_W-1:0]         r_count;

    logic [USERS_W-1:0]       n_pick_users;
    logic signed [REST_W-1:0] n_pick_soft;
    logic signed [REST_W-1:0] n_pick_hard;
    logic                     n_pick_can_load;
    logic [CNT_W-1:0]         n_pick_pos;
    logic                     n_pick_moved;
    logic [CNT_W-1:0]         n_count;

    logic                     r_out_valid;
    logic [POS_W-1:0]         r_out_pos;
    logic                     r_out_can_load;
    logic                     r_out_moved;

    logic                     w_lighter;
    logic                     w_wins;
    logic                     w_replace;
    logic [CNT_W+POS_W-1:0]   w_pos_ext;

    assign o_take = i_item_valid && (!i_item.last || !r_out_valid || i_ready);

    // The margin test is done one bit wider so that it cannot wrap.
    assign w_lighter = ({1'b0, i_item.users} + {1'b0, i_accuracy})
                       <= {1'b0, r_pick_users};

    always_comb begin
        w_wins = 1'b0;
        if (r_pick_soft > 0 && i_item.soft_rest > r_pick_soft) begin
            w_wins = 1'b1;
        end else if (r_pick_soft <= 0 && i_item.soft_rest > 0) begin
            w_wins = 1'b1;
        end else if (r_pick_soft <= 0 && i_item.soft_rest <= 0
                     && i_item.hard_rest > r_pick_hard) begin
            w_wins = 1'b1;
        end
    end

    assign w_replace = (r_count == '0) || !r_pick_can_load
                       || (i_item.can_load && w_lighter && w_wins);

    always_comb begin
        n_pick_users    = r_pick_users;
        n_pick_soft     = r_pick_soft;
        n_pick_hard     = r_pick_hard;
        n_pick_can_load = r_pick_can_load;
        n_pick_pos      = r_pick_pos;
        n_pick_moved    = r_pick_moved;
        if (w_replace) begin
            n_pick_users    = i_item.users;
            n_pick_soft     = i_item.soft_rest;
            n_pick_hard     = i_item.hard_rest;
            n_pick_can_load = i_item.can_load;
            n_pick_pos      = r_count;
            n_pick_moved    = (r_count != '0);
        end
        if (i_item.last) begin
            n_count = '0;
        end else if (r_count < CNT_W'(MAX_HOSTS - 1)) begin
            n_count = r_count + 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    // The reported position is the low bits of the stored position.
    assign w_pos_ext = {{POS_W{1'b0}}, n_pick_pos};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pick_users    <= '0;
            r_pick_soft     <= '0;
            r_pick_hard     <= '0;
            r_pick_can_load <= 1'b0;
            r_pick_pos      <= '0;
            r_pick_moved    <= 1'b0;
            r_count         <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (o_take) begin
                r_pick_users    <= n_pick_users;
                r_pick_soft     <= n_pick_soft;
                r_pick_hard     <= n_pick_hard;
                r_pick_can_load <= n_pick_can_load;
                r_pick_pos      <= n_pick_pos;
                r_pick_moved    <= n_pick_moved;
                r_count         <= n_count;
            end
            if (o_take && i_item.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_item.last) begin
            r_out_pos      <= w_pos_ext[POS_W-1:0];
            r_out_can_load <= n_pick_can_load;
            r_out_moved    <= n_pick_moved;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_chosen_position = r_out_pos;
    assign o_chosen_can_load = r_out_can_load;
    assign o_order_changed   = r_out_moved;

    a_moved_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pick_moved |-> r_pick_pos != '0)
        else $error("pick marked as moved but sits at the first position");

    a_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && i_item.last |=> r_count == '0)
        else $error("record counter not cleared after the last record");

    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_HOSTS - 1))
        else $error("record counter beyond its saturation value");

    a_first_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && r_count == '0 |=> !r_pick_moved && r_pick_pos == '0)
        else $error("first record of a selection did not become the pick");

endmodule
